// ===== sv/tccw_pkg.sv =====
// Shared constants and control types for the text console cell writer.
package tccw_pkg;

	localparam int ROW_CELLS  = 80;
	localparam int LINE_LIMIT = 55;
	localparam int CELL_SPACE = 8192;
	localparam int MAX_DIGITS = 10;

	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int NUM_W  = 31;
	localparam int COL_W  = 4;
	localparam int ADDR_W = 13;
	localparam int CELL_W = 16;
	localparam int CUR_W  = 14;
	localparam int LINE_W = 6;
	localparam int DIG_W  = 4;
	localparam int IDX_W  = $clog2(MAX_DIGITS);
	localparam int BIT_W  = $clog2(NUM_W);

	localparam logic [CMD_W-1:0] CMD_CHAR    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_NEWLINE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DECIMAL = 2'd2;
	localparam logic [CMD_W-1:0] CMD_INIT    = 2'd3;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;

	typedef struct packed {
		logic load;
		logic conv;
		logic top;
		logic emit;
	} tccw_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             conv_done;
		logic             dig_last;
		logic             out_free;
	} tccw_sts_t;

endpackage

// ===== sv/tccw_cmd_if.sv =====
// Command channel: one console command word per handshake.
interface tccw_cmd_if
	import tccw_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [CHAR_W-1:0] char_code;
	logic [NUM_W-1:0]  number;
	logic [COL_W-1:0]  fg_color;
	logic [COL_W-1:0]  bg_color;

	modport source (output valid, cmd, char_code, number, fg_color, bg_color, input ready);
	modport sink (input valid, cmd, char_code, number, fg_color, bg_color, output ready);
endinterface

// ===== sv/tccw_res_if.sv =====
// Result channel: one cell write / clear request word per handshake.
interface tccw_res_if
	import tccw_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              write_valid;
	logic [ADDR_W-1:0] cell_address;
	logic [CELL_W-1:0] cell_value;
	logic              clear_screen;
	logic              out_of_range;
	logic              last;

	modport source (output valid, write_valid, cell_address, cell_value, clear_screen,
		out_of_range, last, input ready);
	modport sink (input valid, write_valid, cell_address, cell_value, clear_screen,
		out_of_range, last, output ready);
endinterface

// ===== sv/text_console_cell_writer_unit.sv =====
// Text console cell writer: console commands in, text cell writes out.
// Characters, new line and init: the command is registered, then one word is emitted into the output register.
// Decimal: conversion, then a digit search, then one word per cycle per digit while the output register is free;
// the conversion is a 31-step shift-and-add-3 loop.
// Throughput: one item at a time; the next is accepted once the last word is registered.
// Reset: cursor 0, next line 1, no pending word; the digit register is not cleared.
module text_console_cell_writer_unit
	import tccw_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	tccw_cmd_if.sink    cmd_ch,
	tccw_res_if.source  res_ch
);

	tccw_ctl_t ctl;
	tccw_sts_t sts;

	tccw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.in_cmd   (cmd_ch.cmd),
		.sts      (sts),
		.in_ready (cmd_ch.ready),
		.ctl      (ctl)
	);

	tccw_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.in_cmd          (cmd_ch.cmd),
		.in_char         (cmd_ch.char_code),
		.in_number       (cmd_ch.number),
		.in_fg           (cmd_ch.fg_color),
		.in_bg           (cmd_ch.bg_color),
		.out_ready       (res_ch.ready),
		.out_valid       (res_ch.valid),
		.out_write_valid (res_ch.write_valid),
		.out_address     (res_ch.cell_address),
		.out_value       (res_ch.cell_value),
		.out_clear       (res_ch.clear_screen),
		.out_oor         (res_ch.out_of_range),
		.out_last        (res_ch.last)
	);

	// a new word never overwrites one that is still pending
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> sts.out_free)
		else $error("word emitted while output register busy");

	// not ready again in the cycle right after an accepted command
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ch.valid && cmd_ch.ready) |=> !cmd_ch.ready)
		else $error("command accepted on consecutive cycles");

	// a cell write is never also a clear or a suppressed write
	a_word_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && res_ch.write_valid) |-> (!res_ch.clear_screen && !res_ch.out_of_range))
		else $error("inconsistent result word");

	a_ctl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.conv, ctl.top, ctl.emit}))
		else $error("overlapping datapath commands");

endmodule

// ===== sv/tccw_ctrl.sv =====
// Sequencer: accept, binary-to-BCD conversion, digit search, result emission.
module tccw_ctrl
	import tccw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_cmd,
	input  tccw_sts_t        sts,
	output logic             in_ready,
	output tccw_ctl_t        ctl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_TOP  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		state_n  = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_n  = (in_cmd == CMD_DECIMAL) ? ST_CONV : ST_EMIT;
				end
			end
			ST_CONV: begin
				ctl.conv = 1'b1;
				if (sts.conv_done)
					state_n = ST_TOP;
			end
			ST_TOP: begin
				ctl.top = 1'b1;
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					if (sts.cmd != CMD_DECIMAL || sts.dig_last)
						state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

endmodule

// ===== sv/tccw_dp.sv =====
// Datapath: cursor and line state, double-dabble digit register, output register.
module tccw_dp
	import tccw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  tccw_ctl_t         ctl,
	output tccw_sts_t         sts,
	input  logic [CMD_W-1:0]  in_cmd,
	input  logic [CHAR_W-1:0] in_char,
	input  logic [NUM_W-1:0]  in_number,
	input  logic [COL_W-1:0]  in_fg,
	input  logic [COL_W-1:0]  in_bg,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              out_write_valid,
	output logic [ADDR_W-1:0] out_address,
	output logic [CELL_W-1:0] out_value,
	output logic              out_clear,
	output logic              out_oor,
	output logic              out_last
);

	logic [CUR_W-1:0]  cursor_q;
	logic [LINE_W-1:0] next_line_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [CHAR_W-1:0] char_q;
	logic [COL_W-1:0]  fg_q;
	logic [COL_W-1:0]  bg_q;
	logic [NUM_W-1:0]  num_q;
	logic [MAX_DIGITS-1:0][DIG_W-1:0] bcd_q;
	logic [BIT_W-1:0]  bit_cnt_q;
	logic [IDX_W-1:0]  dig_idx_q;

	logic              ov_q, wv_q, clr_q, oor_q, last_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CELL_W-1:0] val_q;

	logic [MAX_DIGITS-1:0][DIG_W-1:0] adj;
	logic [MAX_DIGITS*DIG_W-1:0] adj_flat;
	logic [IDX_W-1:0]  top_idx;
	logic              out_free;

	// result of the current emission
	logic              r_wv, r_clr, r_oor, r_last;
	logic [ADDR_W-1:0] r_addr;
	logic [CELL_W-1:0] r_val;
	logic [CUR_W-1:0]  cursor_n;
	logic [LINE_W-1:0] next_line_n;
	logic [CHAR_W-1:0] ch;
	logic [CELL_W-1:0] fill;
	logic [LINE_W-1:0] nl_eff;
	logic [CUR_W:0]    pos;

	// add-3 correction on every BCD digit before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++)
			adj[i] = (bcd_q[i] >= DIG_W'(5)) ? bcd_q[i] + DIG_W'(3) : bcd_q[i];
		adj_flat = adj;
	end

	// most significant nonzero digit, 0 when the number is zero
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < MAX_DIGITS; i++)
			if (bcd_q[i] != '0)
				top_idx = IDX_W'(i);
	end

	assign out_free = !ov_q || out_ready;

	always_comb begin
		fill        = {bg_q, fg_q, CHAR_NUL};
		ch          = (cmd_q == CMD_CHAR) ? char_q : (CHAR_ZERO | CHAR_W'(bcd_q[dig_idx_q]));
		r_wv        = 1'b0;
		r_addr      = '0;
		r_val       = '0;
		r_clr       = 1'b0;
		r_oor       = 1'b0;
		r_last      = 1'b1;
		cursor_n    = cursor_q;
		next_line_n = next_line_q;
		nl_eff      = next_line_q;
		pos         = '0;
		case (cmd_q)
			CMD_CHAR, CMD_DECIMAL: begin
				if (cmd_q == CMD_DECIMAL)
					r_last = (dig_idx_q == '0);
				if (cursor_q < CUR_W'(CELL_SPACE)) begin
					r_wv     = 1'b1;
					r_addr   = cursor_q[ADDR_W-1:0];
					r_val    = {bg_q, fg_q, ch};
					cursor_n = cursor_q + 1'b1;
				end else begin
					r_oor    = 1'b1;
					cursor_n = CUR_W'(CELL_SPACE);
				end
			end
			CMD_NEWLINE: begin
				if (next_line_q >= LINE_W'(LINE_LIMIT)) begin
					nl_eff = '0;
					r_clr  = 1'b1;
					r_val  = fill;
				end
				pos         = (CUR_W+1)'(ROW_CELLS) * (CUR_W+1)'(nl_eff);
				cursor_n    = (pos > (CUR_W+1)'(CELL_SPACE)) ? CUR_W'(CELL_SPACE)
				                                             : pos[CUR_W-1:0];
				next_line_n = nl_eff + 1'b1;
			end
			default: begin
				r_clr       = 1'b1;
				r_val       = fill;
				cursor_n    = '0;
				next_line_n = LINE_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			next_line_q <= LINE_W'(1);
			ov_q        <= 1'b0;
		end else begin
			if (ctl.emit) begin
				cursor_q    <= cursor_n;
				next_line_q <= next_line_n;
			end
			if (ctl.emit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q     <= in_cmd;
			char_q    <= in_char;
			fg_q      <= in_fg;
			bg_q      <= in_bg;
			num_q     <= in_number;
			bcd_q     <= '0;
			bit_cnt_q <= BIT_W'(NUM_W - 1);
		end
		if (ctl.conv) begin
			bcd_q     <= {adj_flat[MAX_DIGITS*DIG_W-2:0], num_q[NUM_W-1]};
			num_q     <= {num_q[NUM_W-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q - 1'b1;
		end
		if (ctl.top)
			dig_idx_q <= top_idx;
		else if (ctl.emit && cmd_q == CMD_DECIMAL && dig_idx_q != '0)
			dig_idx_q <= dig_idx_q - 1'b1;
		if (ctl.emit) begin
			wv_q   <= r_wv;
			addr_q <= r_addr;
			val_q  <= r_val;
			clr_q  <= r_clr;
			oor_q  <= r_oor;
			last_q <= r_last;
		end
	end

	assign sts.cmd       = cmd_q;
	assign sts.conv_done = (bit_cnt_q == '0);
	assign sts.dig_last  = (dig_idx_q == '0);
	assign sts.out_free  = out_free;

	assign out_valid       = ov_q;
	assign out_write_valid = wv_q;
	assign out_address     = addr_q;
	assign out_value       = val_q;
	assign out_clear       = clr_q;
	assign out_oor         = oor_q;
	assign out_last        = last_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the text console cell writer: random console commands, cell word check.
module tb;
	import tccw_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 300;
	localparam int END_CYCLES  = 60;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CHAR_W-1:0] char_code;
		logic [NUM_W-1:0]  number;
		logic [COL_W-1:0]  fg_color;
		logic [COL_W-1:0]  bg_color;
	} console_cmd_t;

	typedef struct packed {
		logic              write_valid;
		logic [ADDR_W-1:0] cell_address;
		logic [CELL_W-1:0] cell_value;
		logic              clear_screen;
		logic              out_of_range;
		logic              last;
	} cell_word_t;

	logic clk = 1'b0;
	logic arst_n;

	tccw_cmd_if cmd_ch();
	tccw_res_if res_ch();

	text_console_cell_writer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	console_cmd_t pending_cmds[$];
	cell_word_t   expected_cells[$];

	int model_cursor = 0;
	int model_line   = 1;
	int errors       = 0;
	int cycles       = 0;
	int queued_cmds  = 0;
	int taken_cmds   = 0;
	int send_gap     = 0;
	int recv_gap     = 0;
	int recv_hold    = 0;
	int long_hold    = 0;
	bit quiet        = 1'b0;
	bit cmd_fire     = 1'b0;
	bit res_fire     = 1'b0;

	task automatic queue_cmd(input console_cmd_t c);
		pending_cmds.push_back(c);
		queued_cmds++;
	endtask

	task automatic emit_char(input logic [CHAR_W-1:0] ch, input logic [COL_W-1:0] fg,
		input logic [COL_W-1:0] bg, input logic lst);
		cell_word_t w;
		w = '0;
		w.last = lst;
		if (model_cursor < CELL_SPACE) begin
			w.write_valid  = 1'b1;
			w.cell_address = ADDR_W'(model_cursor);
			w.cell_value   = {bg, fg, ch};
			model_cursor++;
		end else begin
			// cursor pinned at the end of cell space, write dropped
			w.out_of_range = 1'b1;
			model_cursor   = CELL_SPACE;
		end
		expected_cells.push_back(w);
	endtask

	task automatic predict_cells(input console_cmd_t c);
		logic [DIG_W-1:0] digs [MAX_DIGITS];
		logic [NUM_W-1:0] rest;
		cell_word_t w;
		int n;
		int pos;
		w = '0;
		w.last = 1'b1;
		case (c.cmd)
		CMD_CHAR: begin
			emit_char(c.char_code, c.fg_color, c.bg_color, 1'b1);
		end
		CMD_NEWLINE: begin
			if (model_line >= LINE_LIMIT) begin
				model_line     = 0;
				w.clear_screen = 1'b1;
				w.cell_value   = {c.bg_color, c.fg_color, CHAR_NUL};
			end
			expected_cells.push_back(w);
			pos = ROW_CELLS * model_line;
			model_cursor = (pos > CELL_SPACE) ? CELL_SPACE : pos;
			model_line = (model_line + 1) & ((1 << LINE_W) - 1);
		end
		CMD_DECIMAL: begin
			n    = 0;
			rest = c.number;
			do begin
				digs[n] = DIG_W'(rest % 10);
				rest    = rest / 10;
				n++;
			end while (rest != 0 && n < MAX_DIGITS);
			// most significant digit first
			for (int i = n - 1; i >= 0; i--)
				emit_char(CHAR_ZERO + {4'd0, digs[i]}, c.fg_color, c.bg_color, i == 0);
		end
		CMD_INIT: begin
			w.clear_screen = 1'b1;
			w.cell_value   = {c.bg_color, c.fg_color, CHAR_NUL};
			expected_cells.push_back(w);
			model_cursor = 0;
			model_line   = 1;
		end
		endcase
	endtask

	task automatic check_field(input string name, input logic [CELL_W-1:0] want,
		input logic [CELL_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	function automatic console_cmd_t rand_cmd();
		console_cmd_t c;
		int pick;
		c.char_code = CHAR_W'($urandom);
		c.fg_color  = COL_W'($urandom);
		c.bg_color  = COL_W'($urandom);
		case ($urandom_range(0, 3))
		0: c.number = NUM_W'($urandom);
		1: c.number = NUM_W'($urandom_range(0, 99));
		2: c.number = NUM_W'($urandom_range(0, 99999));
		default: c.number = NUM_W'($urandom_range(0, 9));
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 40)
			c.cmd = CMD_CHAR;
		else if (pick < 68)
			c.cmd = CMD_NEWLINE;
		else if (pick < 95)
			c.cmd = CMD_DECIMAL;
		else
			c.cmd = CMD_INIT;
		return c;
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || taken_cmds != queued_cmds
			|| expected_cells.size() != 0)
			@(negedge clk);
	endtask

	// sample both handshakes, check result words, predict accepted commands
	always @(posedge clk) begin : monitor
		cell_word_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("tb NOT OK");
			$finish;
		end
		cmd_fire = arst_n && cmd_ch.valid && cmd_ch.ready;
		res_fire = arst_n && res_ch.valid && res_ch.ready;
		if (res_fire) begin
			if (expected_cells.size() == 0) begin
				errors++;
				$display("%0t: unexpected word expected none actual %h %h %h %h %h %h", $time,
					res_ch.write_valid, res_ch.cell_address, res_ch.cell_value,
					res_ch.clear_screen, res_ch.out_of_range, res_ch.last);
			end else begin
				want = expected_cells.pop_front();
				check_field("write_valid", want.write_valid, res_ch.write_valid);
				check_field("cell_address", want.cell_address, res_ch.cell_address);
				check_field("cell_value", want.cell_value, res_ch.cell_value);
				check_field("clear_screen", want.clear_screen, res_ch.clear_screen);
				check_field("out_of_range", want.out_of_range, res_ch.out_of_range);
				check_field("last", want.last, res_ch.last);
			end
		end
		if (cmd_fire) begin
			predict_cells('{cmd_ch.cmd, cmd_ch.char_code, cmd_ch.number,
				cmd_ch.fg_color, cmd_ch.bg_color});
			taken_cmds++;
		end
	end

	always @(negedge clk) begin : driver
		console_cmd_t c;
		// hold the word until it is taken
		if (arst_n && !(cmd_ch.valid && !cmd_fire)) begin
			if (send_gap > 0) begin
				send_gap--;
				cmd_ch.valid <= 1'b0;
			end else if (pending_cmds.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 14);
				cmd_ch.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				c = pending_cmds.pop_front();
				cmd_ch.cmd       <= c.cmd;
				cmd_ch.char_code <= c.char_code;
				cmd_ch.number    <= c.number;
				cmd_ch.fg_color  <= c.fg_color;
				cmd_ch.bg_color  <= c.bg_color;
				cmd_ch.valid     <= 1'b1;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (long_hold > 0) begin
				recv_hold = long_hold;
				long_hold = 0;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				res_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				res_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 14);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		console_cmd_t c;
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.cmd       = CMD_CHAR;
		cmd_ch.char_code = '0;
		cmd_ch.number    = '0;
		cmd_ch.fg_color  = '0;
		cmd_ch.bg_color  = '0;
		res_ch.ready     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, zero, widest number, the init clear path
		queue_cmd('{CMD_CHAR, 8'h00, 31'd0, 4'd0, 4'd0});
		queue_cmd('{CMD_CHAR, 8'hFF, 31'h7FFFFFFF, 4'd15, 4'd15});
		queue_cmd('{CMD_CHAR, 8'h41, 31'd0, 4'd15, 4'd0});
		queue_cmd('{CMD_NEWLINE, 8'h00, 31'd0, 4'd3, 4'd12});
		queue_cmd('{CMD_DECIMAL, 8'h00, 31'd0, 4'd7, 4'd1});
		queue_cmd('{CMD_DECIMAL, 8'hFF, 31'd9, 4'd0, 4'd15});
		queue_cmd('{CMD_DECIMAL, 8'h00, 31'd10, 4'd15, 4'd0});
		queue_cmd('{CMD_DECIMAL, 8'h00, 31'h7FFFFFFF, 4'd15, 4'd15});
		queue_cmd('{CMD_DECIMAL, 8'h00, 31'd1000000000, 4'd5, 4'd10});
		queue_cmd('{CMD_INIT, 8'h00, 31'd0, 4'd15, 4'd15});
		queue_cmd('{CMD_NEWLINE, 8'hFF, 31'h7FFFFFFF, 4'd0, 4'd0});
		queue_cmd('{CMD_CHAR, 8'h7E, 31'd0, 4'd10, 4'd5});
		queue_cmd('{CMD_INIT, 8'h00, 31'd0, 4'd0, 4'd0});
		wait_drained();

		for (int i = 0; i < 40; i++)
			queue_cmd(rand_cmd());
		// sink stalls long while the source keeps offering
		while (taken_cmds < queued_cmds - 30)
			@(negedge clk);
		@(posedge clk);
		long_hold = LONG_HOLD;
		// source pauses until every word is back
		wait_drained();

		// walk to the last line, then print until cell space runs out
		c = rand_cmd();
		c.cmd = CMD_INIT;
		queue_cmd(c);
		for (int i = 0; i < LINE_LIMIT - 1; i++) begin
			c = rand_cmd();
			c.cmd = CMD_NEWLINE;
			queue_cmd(c);
		end
		for (int i = 0; i < 390; i++) begin
			c = rand_cmd();
			c.cmd    = CMD_DECIMAL;
			c.number = NUM_W'($urandom_range(1000000000, 2147483647));
			queue_cmd(c);
		end
		for (int i = 0; i < 4; i++) begin
			c = rand_cmd();
			c.cmd = CMD_CHAR;
			queue_cmd(c);
		end
		c = rand_cmd();
		c.cmd = CMD_DECIMAL;
		queue_cmd(c);
		// line limit reached: this new line asks for a fill
		c = rand_cmd();
		c.cmd = CMD_NEWLINE;
		queue_cmd(c);
		for (int i = 0; i < 8; i++)
			queue_cmd(rand_cmd());
		wait_drained();

		quiet = 1'b1;
		for (int i = 0; i < 20; i++)
			queue_cmd(rand_cmd());
		wait_drained();
		repeat (END_CYCLES) @(negedge clk);

		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== text_console_cell_writer_unit.f =====
sv/tccw_pkg.sv
sv/tccw_cmd_if.sv
sv/tccw_res_if.sv
sv/tccw_ctrl.sv
sv/tccw_dp.sv
sv/text_console_cell_writer_unit.sv
tb/tb.sv
